// File: src/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned SIG_W       = 8;
  localparam int unsigned TS_W        = 64;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned TIMEOUT_W   = 32;
  localparam int unsigned MS_W        = 10;
  localparam int unsigned MAX_AGE_W   = TIMEOUT_W + MS_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [MS_W-1:0]    MS_PER_SECOND = MS_W'(1000);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  // Operation codes
  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_PRUNE  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_DISABLED = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = CFG_IDX_W'(1);

  // Sequencer states
  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_ACT,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    op_e                     operation;
    logic [ADDR_W-1:0]       station_address;
    logic signed [SIG_W-1:0] signal_dbm;
    logic [TS_W-1:0]         now_ms;
  } sst_in_t;

  typedef struct packed {
    logic                    found;
    logic signed [SIG_W-1:0] stored_signal;
    logic [TS_W-1:0]         stored_timestamp;
    status_e                 status;
    logic [COUNT_W-1:0]      removed_count;
  } sst_out_t;

  // One table record as held in memory
  typedef struct packed {
    logic                    valid;
    logic [ADDR_W-1:0]       address;
    logic signed [SIG_W-1:0] signal;
    logic [TS_W-1:0]         timestamp;
  } sst_entry_t;

  localparam int unsigned ENTRY_W = $bits(sst_entry_t);

  // Settings seen by the sequencer
  typedef struct packed {
    logic                 enable;
    logic                 prune_on;
    logic [MAX_AGE_W-1:0] max_age;
  } sst_cfg_t;

endpackage

// File: src/sst_ram.sv
`timescale 1ns / 1ps

module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: src/sst_cfg.sv
`timescale 1ns / 1ps

module sst_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sst_pkg::sst_cfg_t              cfg_o
);

  logic                              enable_q;
  logic [sst_pkg::TIMEOUT_W-1:0]     timeout_q;
  logic [sst_pkg::MAX_AGE_W-1:0]     max_age_q;
  logic [sst_pkg::MAX_AGE_W-1:0]     max_age_d;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      timeout_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sst_pkg::CFG_TABLE_ENABLE: enable_q  <= cfg_data_i[0];
        sst_pkg::CFG_TIMEOUT:      timeout_q <= cfg_data_i[sst_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Age limit in ms, registered after the multiply
  assign max_age_d = sst_pkg::MAX_AGE_W'(timeout_q) *
                     sst_pkg::MAX_AGE_W'(sst_pkg::MS_PER_SECOND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= '0;
    end else begin
      max_age_q <= max_age_d;
    end
  end

  assign cfg_o.enable   = enable_q;
  assign cfg_o.prune_on = (timeout_q != '0);
  assign cfg_o.max_age  = max_age_q;

endmodule

// File: src/sst_engine.sv
`timescale 1ns / 1ps

module sst_engine #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sst_pkg::sst_cfg_t      cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sst_pkg::sst_in_t       in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sst_pkg::sst_out_t      out_data_o,
  output logic                   rd_en_o,
  output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr_o,
  input  logic [sst_pkg::ENTRY_W-1:0] rd_data_i,
  output logic                   wr_en_o,
  output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_addr_o,
  output logic [sst_pkg::ENTRY_W-1:0] wr_data_o
);

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = AW + 1;
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

  sst_pkg::fsm_e state_q, state_d;

  sst_pkg::sst_in_t        req_q, req_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]           cmp_idx_q, cmp_idx_d;
  logic                    hit_q, hit_d;
  logic [AW-1:0]           hit_idx_q, hit_idx_d;
  logic signed [sst_pkg::SIG_W-1:0] hit_sig_q, hit_sig_d;
  logic [sst_pkg::TS_W-1:0] hit_ts_q, hit_ts_d;
  logic                    free_q, free_d;
  logic [AW-1:0]           free_idx_q, free_idx_d;
  logic [sst_pkg::COUNT_W-1:0] rem_q, rem_d;
  sst_pkg::sst_out_t       res_q, res_d;
  sst_pkg::sst_out_t       out_q, out_d;
  logic                    out_vld_q, out_vld_d;

  sst_pkg::sst_entry_t     ent;
  sst_pkg::sst_entry_t     wr_ent;
  logic [sst_pkg::TS_W-1:0] age;
  logic                    stale;
  logic                    out_free;

  assign ent      = sst_pkg::sst_entry_t'(rd_data_i);
  assign age      = req_q.now_ms - ent.timestamp;
  assign stale    = ent.valid && cfg_i.prune_on &&
                    (age > sst_pkg::TS_W'(cfg_i.max_age));
  assign out_free = !out_vld_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sst_pkg::FSM_CLEAR: if (cnt_q == CNT_LAST) state_d = sst_pkg::FSM_IDLE;
      sst_pkg::FSM_IDLE:  if (in_valid_i) state_d = sst_pkg::FSM_SCAN;
      sst_pkg::FSM_SCAN:  if (cnt_q == CNT_END) state_d = sst_pkg::FSM_ACT;
      sst_pkg::FSM_ACT:   state_d = sst_pkg::FSM_RESP;
      sst_pkg::FSM_RESP:  if (out_free) state_d = sst_pkg::FSM_IDLE;
      default:            state_d = sst_pkg::FSM_CLEAR;
    endcase
  end

  // Memory control and datapath
  always_comb begin
    req_d      = req_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_sig_d  = hit_sig_q;
    hit_ts_d   = hit_ts_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    rem_d      = rem_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = cnt_q[AW-1:0];
    wr_en_o    = 1'b0;
    wr_addr_o  = cmp_idx_q;
    wr_ent     = '0;

    case (state_q)
      // Sweep zero records through the table after reset
      sst_pkg::FSM_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = cnt_q[AW-1:0];
        cnt_d     = cnt_q + CNT_W'(1);
      end

      sst_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d  = in_data_i;
          cnt_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          rem_d  = '0;
        end
      end

      // Read one record a cycle, check the previous one
      sst_pkg::FSM_SCAN: begin
        if (cnt_q != CNT_END) begin
          rd_en_o   = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[AW-1:0];
        end
        if (cmp_vld_q) begin
          if (ent.valid && (ent.address == req_q.station_address) && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_sig_d = ent.signal;
            hit_ts_d  = ent.timestamp;
          end
          if (!ent.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          // Age out: write back with valid cleared
          if ((req_q.operation == sst_pkg::OP_PRUNE) && stale) begin
            wr_en_o      = 1'b1;
            wr_addr_o    = cmp_idx_q;
            wr_ent       = ent;
            wr_ent.valid = 1'b0;
            if (rem_q != sst_pkg::COUNT_MAX) begin
              rem_d = rem_q + sst_pkg::COUNT_W'(1);
            end
          end
        end
      end

      // Apply the operation and form the result
      sst_pkg::FSM_ACT: begin
        res_d.found            = hit_q;
        res_d.stored_signal    = '0;
        res_d.stored_timestamp = '0;
        res_d.status           = sst_pkg::STAT_DONE;
        res_d.removed_count    = '0;
        wr_ent.valid     = 1'b1;
        wr_ent.address   = req_q.station_address;
        wr_ent.signal    = req_q.signal_dbm;
        wr_ent.timestamp = req_q.now_ms;
        case (req_q.operation)
          sst_pkg::OP_UPDATE: begin
            if (!cfg_i.enable) begin
              res_d.status = sst_pkg::STAT_DISABLED;
              if (hit_q) begin
                res_d.stored_signal    = hit_sig_q;
                res_d.stored_timestamp = hit_ts_q;
              end
            end else if (hit_q) begin
              if ((hit_sig_q == '0) || (req_q.signal_dbm >= hit_sig_q)) begin
                wr_en_o                = 1'b1;
                wr_addr_o              = hit_idx_q;
                res_d.stored_signal    = req_q.signal_dbm;
                res_d.stored_timestamp = req_q.now_ms;
              end else begin
                res_d.stored_signal    = hit_sig_q;
                res_d.stored_timestamp = hit_ts_q;
              end
            end else if (free_q) begin
              wr_en_o                = 1'b1;
              wr_addr_o              = free_idx_q;
              res_d.stored_signal    = req_q.signal_dbm;
              res_d.stored_timestamp = req_q.now_ms;
            end else begin
              res_d.status = sst_pkg::STAT_FULL;
            end
          end
          sst_pkg::OP_DELETE: begin
            if (hit_q) begin
              wr_en_o             = 1'b1;
              wr_addr_o           = hit_idx_q;
              wr_ent.valid        = 1'b0;
              res_d.removed_count = sst_pkg::COUNT_W'(1);
            end
          end
          sst_pkg::OP_FIND: begin
            if (hit_q) begin
              res_d.stored_signal    = hit_sig_q;
              res_d.stored_timestamp = hit_ts_q;
            end
          end
          sst_pkg::OP_PRUNE: begin
            res_d.found         = 1'b0;
            res_d.removed_count = rem_q;
          end
          default: ;
        endcase
      end

      // Hand the result to the output register once it is free
      sst_pkg::FSM_RESP: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end

      default: ;
    endcase
  end

  assign wr_data_o   = wr_ent;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sst_pkg::FSM_CLEAR;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_sig_q  <= hit_sig_d;
    hit_ts_q   <= hit_ts_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

// File: src/station_signal_table_with_aging.sv
`timescale 1ns / 1ps
// Items: an item is taken only in the idle state, and the next is not accepted until
// the result of the last has gone to the output register, since every record is
// walked through the single read port of the table memory for each item.
// Reset: asynchronous, active low; afterwards a clearing pass writes a zero record
// to each of the TABLE_ENTRIES table entries before the first item is taken.

module station_signal_table_with_aging #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sst_pkg::sst_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sst_pkg::sst_out_t              out_data_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  sst_pkg::sst_cfg_t             cfg;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [sst_pkg::ENTRY_W-1:0]   rd_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [sst_pkg::ENTRY_W-1:0]   wr_data;

  // Configuration registers
  sst_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Table memory
  sst_ram #(
    .WIDTH (sst_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Scan and update sequencer
  sst_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

endmodule
